>>> rtl/core/plist_pkg.sv
`timescale 1ns / 1ps
// Package for the positional list engine: sizes, opcode and status codes,
// and the structs passed between the sequencer, the entry store and the top level.
// No dependencies.
package plist_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = POS_W + 1;

    typedef enum logic [1:0] {
        OP_APPEND      = 2'd0,
        OP_REMOVE_REAR = 2'd1,
        OP_INSERT      = 2'd2,
        OP_REMOVE_AT   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] removed_value;
        logic              removed_valid;
        logic [CNT_W-1:0]  list_length;
    } t_result;

endpackage

>>> rtl/core/plist_store.sv
`timescale 1ns / 1ps
// Entry store of the positional list engine: one write port, one registered read port.
// Depends on plist_pkg.
module plist_store (
    input  logic                      i_clk,
    input  plist_pkg::t_mem_req       i_req,
    output logic [plist_pkg::DATA_W-1:0] o_rdata
);
    import plist_pkg::*;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/plist_ctrl.sv
`timescale 1ns / 1ps
// Request decoder and shift sequencer of the positional list engine.
// Moves entries one place per cycle through the entry store. Depends on plist_pkg.
module plist_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [plist_pkg::DATA_W-1:0]  i_item_value,
    input  logic [plist_pkg::POS_W-1:0]   i_position,
    output plist_pkg::t_mem_req           o_mem_req,
    input  logic [plist_pkg::DATA_W-1:0]  i_mem_rdata,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output plist_pkg::t_result            o_res
);
    import plist_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_FINAL,
        S_RESP
    } t_state;

    t_state            r_state,      n_state;
    logic [CNT_W-1:0]  r_count,      n_count;
    logic              r_is_ins,     n_is_ins;
    logic [IDX_W-1:0]  r_idx,        n_idx;
    logic [DATA_W-1:0] r_val,        n_val;
    logic [CNT_W-1:0]  r_left,       n_left;
    logic [IDX_W-1:0]  r_rd,         n_rd;
    logic              r_first,      n_first;
    logic              r_pend,       n_pend;
    logic              r_pend_first, n_pend_first;
    logic [IDX_W-1:0]  r_pend_addr,  n_pend_addr;
    t_status           r_status,     n_status;
    logic [DATA_W-1:0] r_removed,    n_removed;
    logic              r_rvalid,     n_rvalid;

    t_opcode           dec_op;
    t_status           dec_status;
    logic              dec_ins;
    logic              dec_full;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  idx_x;
    logic [IDX_W-1:0]  dec_idx;

    always_comb begin
        dec_op   = t_opcode'(i_opcode);
        pos_x    = CMP_W'(i_position);
        cnt_x    = CMP_W'(r_count);
        dec_full = (r_count == CNT_W'(CAPACITY));
        dec_ins  = 1'b0;
        idx_x    = pos_x - 1'b1;
        dec_status = ST_OK;
        case (dec_op)
            OP_APPEND: begin
                dec_ins = 1'b1;
                idx_x   = cnt_x;
                if (dec_full) begin
                    dec_status = ST_FULL;
                end
            end
            OP_REMOVE_REAR: begin
                idx_x = cnt_x - 1'b1;
                if (r_count == '0) begin
                    dec_status = ST_EMPTY;
                end
            end
            OP_INSERT: begin
                dec_ins = 1'b1;
                if (dec_full) begin
                    dec_status = ST_FULL;
                end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                    dec_status = ST_BADPOS;
                end
            end
            OP_REMOVE_AT: begin
                if (r_count == '0 || pos_x == '0 || pos_x > cnt_x) begin
                    dec_status = ST_BADPOS;
                end
            end
            default: begin
                dec_status = ST_BADPOS;
            end
        endcase
        dec_idx = idx_x[IDX_W-1:0];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_is_ins     = r_is_ins;
        n_idx        = r_idx;
        n_val        = r_val;
        n_left       = r_left;
        n_rd         = r_rd;
        n_first      = r_first;
        n_pend       = r_pend;
        n_pend_first = r_pend_first;
        n_pend_addr  = r_pend_addr;
        n_status     = r_status;
        n_removed    = r_removed;
        n_rvalid     = r_rvalid;
        o_mem_req    = '0;
        o_res_valid  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status  = dec_status;
                    n_removed = '0;
                    n_rvalid  = 1'b0;
                    if (dec_status == ST_OK) begin
                        n_is_ins = dec_ins;
                        n_idx    = dec_idx;
                        n_val    = i_item_value;
                        n_left   = r_count - CNT_W'(dec_idx);
                        n_rd     = dec_ins ? IDX_W'(r_count - 1'b1) : dec_idx;
                        n_first  = 1'b1;
                        n_pend   = 1'b0;
                        n_state  = S_SHIFT;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SHIFT: begin
                // retire the read issued last cycle
                if (r_pend) begin
                    if (!r_is_ins && r_pend_first) begin
                        n_removed = i_mem_rdata;
                        n_rvalid  = 1'b1;
                    end else begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = r_is_ins ? r_pend_addr + 1'b1 : r_pend_addr - 1'b1;
                        o_mem_req.wdata = i_mem_rdata;
                    end
                end
                // issue the next read
                if (r_left != '0) begin
                    o_mem_req.raddr = r_rd;
                    n_pend          = 1'b1;
                    n_pend_addr     = r_rd;
                    n_pend_first    = r_first;
                    n_first         = 1'b0;
                    n_rd            = r_is_ins ? r_rd - 1'b1 : r_rd + 1'b1;
                    n_left          = r_left - 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                if (r_is_ins) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_idx;
                    o_mem_req.wdata = r_val;
                    n_count         = r_count + 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_is_ins     <= n_is_ins;
        r_idx        <= n_idx;
        r_val        <= n_val;
        r_left       <= n_left;
        r_rd         <= n_rd;
        r_first      <= n_first;
        r_pend_first <= n_pend_first;
        r_pend_addr  <= n_pend_addr;
        r_status     <= n_status;
        r_removed    <= n_removed;
        r_rvalid     <= n_rvalid;
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_res.status        = r_status;
        o_res.removed_value = r_removed;
        o_res.removed_valid = r_rvalid;
        o_res.list_length   = r_count;
    end

endmodule

>>> rtl/core/positional_list_engine.sv
`timescale 1ns / 1ps
// Positional list engine: ordered list of signed 32-bit entries edited by request.
// Each request beat on the input channel (opcode, item value, 1-based position)
// gives one result beat (status, removed value and flag, list length).
// Append, remove rear, insert at position and remove at position are served by
// a sequencer that moves entries one place per cycle through a store with one
// write port and one registered read port. A request that moves entries behind
// its position passes through the shift and final states before its result;
// one that moves none (append, insert at the rear) passes through them with no
// moves, and a rejected request (full, empty, bad position) goes straight to the
// result. One request is in work at a time:
// o_ready is high only while the sequencer is idle, and it rises again in the
// cycle in which the result reaches the output register.
// The result sits in an output register; while the receiver holds i_ready low the
// result beat holds, and the next request is taken once that result has been
// handed to the output register.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result;
// no clearing pass is needed.
// Depends on plist_pkg, plist_ctrl and plist_store.
module positional_list_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_opcode,
    input  logic signed [plist_pkg::DATA_W-1:0] i_item_value,
    input  logic [plist_pkg::POS_W-1:0]         i_position,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic signed [plist_pkg::DATA_W-1:0] o_removed_value,
    output logic                                o_removed_valid,
    output logic [plist_pkg::CNT_W-1:0]         o_list_length
);
    import plist_pkg::*;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    t_result           res;
    logic              res_valid;
    logic              res_ready;
    t_result           r_out;
    logic              r_o_valid;

    plist_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    plist_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_out.status;
    assign o_removed_value = r_out.removed_value;
    assign o_removed_valid = r_out.removed_valid;
    assign o_list_length   = r_out.list_length;

endmodule

>>> rtl/core/plist_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the positional list engine's result channel, and the bind
// that attaches them to the top level. Depends on plist_pkg.
module plist_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [1:0]                          o_status,
    input logic signed [plist_pkg::DATA_W-1:0] o_removed_value,
    input logic                                o_removed_valid,
    input logic [plist_pkg::CNT_W-1:0]         o_list_length
);
    import plist_pkg::*;

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_list_length <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_removed_valid |-> o_status == ST_OK)
        else $error("removed beat without ok status");

    a_no_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_removed_valid |-> o_removed_value == '0)
        else $error("removed value not zero without removal");

    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> o_list_length == CNT_W'(CAPACITY))
        else $error("full status on a list that is not full");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_list_length))
        else $error("stalled result beat changed");

endmodule

bind positional_list_engine plist_checker u_plist_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_status        (o_status),
    .o_removed_value (o_removed_value),
    .o_removed_valid (o_removed_valid),
    .o_list_length   (o_list_length)
);

>>> sim/list_checker.sv
`timescale 1ns / 1ps
// Checker for the positional list engine: watches both channels, keeps its own copy
// of the list, predicts each result beat and compares it field by field.
// Depends on plist_pkg.
module list_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_ready_dut,
    input  logic [1:0]                          i_opcode,
    input  logic signed [plist_pkg::DATA_W-1:0] i_item_value,
    input  logic [plist_pkg::POS_W-1:0]         i_position,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic [1:0]                          i_status,
    input  logic signed [plist_pkg::DATA_W-1:0] i_removed_value,
    input  logic                                i_removed_valid,
    input  logic [plist_pkg::CNT_W-1:0]         i_list_length,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import plist_pkg::*;

    localparam int PRINT_CAP = 100;

    logic [DATA_W-1:0] held_entries [CAPACITY];
    int                held_count = 0;
    t_result           awaited_results [$];
    t_result           want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(string msg);
        if (o_fail_count < PRINT_CAP)
            $display("%0t list_checker: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic t_result edit_list(t_opcode op, logic [DATA_W-1:0] val,
                                          logic [POS_W-1:0] pos);
        t_result r;
        int      p;
        int      k;
        p                = int'(pos);
        r.status         = ST_OK;
        r.removed_value  = '0;
        r.removed_valid  = 1'b0;
        case (op)
            OP_APPEND: begin
                if (held_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    held_entries[held_count] = val;
                    held_count++;
                end
            end
            OP_REMOVE_REAR: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    held_count--;
                    r.removed_value = held_entries[held_count];
                    r.removed_valid = 1'b1;
                end
            end
            OP_INSERT: begin
                if (held_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (p == 0 || p > held_count + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (k = held_count; k > p - 1; k--)
                        held_entries[k] = held_entries[k-1];
                    held_entries[p-1] = val;
                    held_count++;
                end
            end
            default: begin
                if (held_count == 0 || p == 0 || p > held_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.removed_value = held_entries[p-1];
                    r.removed_valid = 1'b1;
                    for (k = p - 1; k < held_count - 1; k++)
                        held_entries[k] = held_entries[k+1];
                    held_count--;
                end
            end
        endcase
        r.list_length = CNT_W'(held_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            awaited_results.delete();
        end else begin
            if (i_valid && i_ready_dut)
                awaited_results.push_back(edit_list(t_opcode'(i_opcode), i_item_value,
                                                    i_position));
            if (i_res_valid && i_res_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result beat with no request waiting");
                end else begin
                    want = awaited_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_status, want.status));
                    if (i_removed_value !== want.removed_value)
                        report_mismatch($sformatf("removed_value got %h want %h",
                                                  i_removed_value, want.removed_value));
                    if (i_removed_valid !== want.removed_valid)
                        report_mismatch($sformatf("removed_valid got %b want %b",
                                                  i_removed_valid, want.removed_valid));
                    if (i_list_length !== want.list_length)
                        report_mismatch($sformatf("list_length got %0d want %0d",
                                                  i_list_length, want.list_length));
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the positional list engine testbench: clock, reset, request and result
// drivers with random idling, a watchdog and the verdict.
// Depends on plist_pkg, positional_list_engine and list_checker.
module tb_top;
    import plist_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int BLOCK_ITEMS  = 50;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_valid      = 1'b0;
    logic                      i_ready      = 1'b0;
    logic [1:0]                i_opcode     = OP_APPEND;
    logic signed [DATA_W-1:0]  i_item_value = '0;
    logic [POS_W-1:0]          i_position   = '0;
    logic                      o_ready;
    logic                      o_valid;
    logic [1:0]                o_status;
    logic signed [DATA_W-1:0]  o_removed_value;
    logic                      o_removed_valid;
    logic [CNT_W-1:0]          o_list_length;

    bit no_idle    = 1'b0;
    bit hold_ready = 1'b0;
    int idle_cycles = 0;
    int fail_count;
    int pending;
    int ready_gap;
    int trend;

    positional_list_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_removed_valid (o_removed_valid),
        .o_list_length   (o_list_length)
    );

    list_checker u_list_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_ready_dut     (o_ready),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_status        (o_status),
        .i_removed_value (o_removed_value),
        .i_removed_valid (o_removed_valid),
        .i_list_length   (o_list_length),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r < 8)
            return POS_W'($urandom_range(1, CAPACITY + 1));
        else
            return POS_W'($urandom_range(0, 255));
    endfunction

    function automatic t_opcode pick_opcode(int bias);
        int r;
        r = $urandom_range(0, 9);
        case (bias)
            0: begin
                if (r < 4)
                    return OP_APPEND;
                if (r < 8)
                    return OP_INSERT;
                if (r == 8)
                    return OP_REMOVE_REAR;
                return OP_REMOVE_AT;
            end
            1: begin
                if (r < 4)
                    return OP_REMOVE_REAR;
                if (r < 8)
                    return OP_REMOVE_AT;
                if (r == 8)
                    return OP_APPEND;
                return OP_INSERT;
            end
            default: return t_opcode'($urandom_range(0, 3));
        endcase
    endfunction

    // hold valid and payload until the beat is taken
    task automatic send_request(t_opcode op, logic [DATA_W-1:0] val, logic [POS_W-1:0] pos);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_item_value <= val;
        i_position   <= pos;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_ready) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_ready = 1'b0;
            end
            ready_gap = draw_gap();
            if (ready_gap > 0) begin
                i_ready <= 1'b0;
                repeat (ready_gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list
        send_request(OP_REMOVE_REAR, 32'h1234_5678, 8'd0);
        send_request(OP_REMOVE_AT,   32'h0,         8'd1);
        send_request(OP_INSERT,      32'h1111_1111, 8'd0);
        send_request(OP_INSERT,      32'h2222_2222, 8'd2);
        // fill
        send_request(OP_INSERT,      32'h8000_0000, 8'd1);
        send_request(OP_APPEND,      32'h7fff_ffff, 8'd0);
        send_request(OP_INSERT,      32'h5555_5555, 8'd3);
        send_request(OP_INSERT,      32'hffff_ffff, 8'd2);
        for (int n = 0; n < CAPACITY - 4; n++)
            send_request(OP_APPEND, (n[0] ? 32'haaaa_aaaa : 32'h0) ^ n, 8'hff);
        // full: fullness wins over position
        send_request(OP_APPEND,      32'h0bad_0bad, 8'd1);
        send_request(OP_INSERT,      32'h0bad_0bad, 8'd0);
        send_request(OP_INSERT,      32'h0bad_0bad, 8'd17);
        // removes at the edges of the position range, then a bad-position insert
        send_request(OP_REMOVE_AT,   32'h0,         8'd0);
        send_request(OP_REMOVE_AT,   32'h0,         8'd17);
        send_request(OP_REMOVE_AT,   32'h0,         8'd255);
        send_request(OP_REMOVE_AT,   32'h0,         8'd16);
        send_request(OP_REMOVE_AT,   32'h0,         8'd1);
        send_request(OP_REMOVE_REAR, 32'h0,         8'd0);
        send_request(OP_INSERT,      32'h0,         8'd255);

        for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
            trend   = $urandom_range(0, 2);
            no_idle = ($urandom_range(0, 3) == 0);
            if (blk == 4)
                hold_ready = 1'b1;
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send_request(pick_opcode(trend), pick_value(), pick_position());
        end
        i_valid <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
